>>> hw/rtl/url_path_sanitiser_defines.svh
// ----------------------------------------------------------------------------
// url_path_sanitiser_defines: assertion macros
// Same-cycle and next-cycle implication checks, reset-qualified.
// ----------------------------------------------------------------------------
`ifndef URL_PATH_SANITISER_DEFINES_SVH
`define URL_PATH_SANITISER_DEFINES_SVH

// Antecedent implies consequent in the same cycle.
`define UPS_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ups: same-cycle check failed");

// Antecedent implies consequent in the next cycle.
`define UPS_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ups: next-cycle check failed");

`endif

>>> hw/rtl/ups_pkg.sv
// ----------------------------------------------------------------------------
// ups_pkg: shared definitions for the URL path sanitizer
// Character codes, pass opcodes, controller states, command/status structs
// and the hex digit decoder and escape code check.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package ups_pkg;

    localparam int DEFAULT_MAX_LEN = 64;

    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_PCT   = 8'h25;
    localparam logic [7:0] CH_QMARK = 8'h3F;
    localparam logic [7:0] CH_HASH  = 8'h23;

    // Operation the datapath performs.
    typedef enum logic [2:0] {
        OP_LOAD,
        OP_SCAN,
        OP_COLLAPSE,
        OP_DECODE,
        OP_EMIT
    } op_t;

    typedef enum logic [2:0] {
        ST_LOAD,
        ST_SCAN,
        ST_COLLAPSE,
        ST_DECODE,
        ST_EMIT
    } state_t;

    typedef struct packed {
        op_t  op;
        logic restart;   // finish current pass, rewind pointers
    } cmd_t;

    typedef struct packed {
        logic last_taken;   // final word of a URL accepted
        logic sweep_done;   // current pass has drained
    } sts_t;

    // {valid, value} of one hex digit, either case.
    function automatic logic [4:0] hex_nibble(input logic [7:0] c);
        logic [7:0] d;
        logic [4:0] r;
        d = 8'h00;
        r = 5'h00;
        if (c >= 8'h30 && c <= 8'h39)
        begin
            d = c - 8'h30;
            r = {1'b1, d[3:0]};
        end
        else if (c >= 8'h41 && c <= 8'h46)
        begin
            d = c - 8'h37;
            r = {1'b1, d[3:0]};
        end
        else if (c >= 8'h61 && c <= 8'h66)
        begin
            d = c - 8'h57;
            r = {1'b1, d[3:0]};
        end
        return r;
    endfunction

    // Codes that a percent escape may decode to.
    function automatic logic esc_known(input logic [7:0] code);
        logic ok;
        ok = 1'b0;
        unique case (code) inside
            8'h20, 8'h23, 8'h24, 8'h25, 8'h26, 8'h2F, 8'h3A, 8'h3B,
            8'h3C, 8'h3D, 8'h3E, 8'h3F, 8'h40, 8'h5B, 8'h5C, 8'h5D,
            8'h5E, 8'h60, 8'h7B, 8'h7C, 8'h7D, 8'h7E: ok = 1'b1;
            default: ok = 1'b0;
        endcase
        return ok;
    endfunction

endpackage

>>> hw/rtl/ups_ctrl.sv
// ----------------------------------------------------------------------------
// ups_ctrl: pass sequencer
// Steps load, scan, collapse, decode and emit passes over the buffer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ups_ctrl
(
    input  logic          clk,
    input  logic          rst_n,
    input  ups_pkg::sts_t sts,
    output ups_pkg::cmd_t cmd
);

    ups_pkg::state_t state_reg;
    ups_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ups_pkg::ST_LOAD;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next  = state_reg;
        cmd.op      = ups_pkg::OP_LOAD;
        cmd.restart = 1'b0;
        unique case (state_reg)
            ups_pkg::ST_LOAD:
            begin
                cmd.op = ups_pkg::OP_LOAD;
                if (sts.last_taken)
                begin
                    cmd.restart = 1'b1;
                    state_next  = ups_pkg::ST_SCAN;
                end
            end
            ups_pkg::ST_SCAN:
            begin
                cmd.op = ups_pkg::OP_SCAN;
                if (sts.sweep_done)
                begin
                    cmd.restart = 1'b1;
                    state_next  = ups_pkg::ST_COLLAPSE;
                end
            end
            ups_pkg::ST_COLLAPSE:
            begin
                cmd.op = ups_pkg::OP_COLLAPSE;
                if (sts.sweep_done)
                begin
                    cmd.restart = 1'b1;
                    state_next  = ups_pkg::ST_DECODE;
                end
            end
            ups_pkg::ST_DECODE:
            begin
                cmd.op = ups_pkg::OP_DECODE;
                if (sts.sweep_done)
                begin
                    cmd.restart = 1'b1;
                    state_next  = ups_pkg::ST_EMIT;
                end
            end
            ups_pkg::ST_EMIT:
            begin
                cmd.op = ups_pkg::OP_EMIT;
                if (sts.sweep_done)
                begin
                    cmd.restart = 1'b1;
                    state_next  = ups_pkg::ST_LOAD;
                end
            end
            default:
            begin
                state_next = ups_pkg::ST_LOAD;
            end
        endcase
    end

endmodule

>>> hw/rtl/ups_dp.sv
// ----------------------------------------------------------------------------
// ups_dp: buffer and pass datapath
// One buffer memory rewritten in place by the collapse and decode passes,
// a read pointer with a registered read, and the output word register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ups_dp
#(
    parameter int MAX_LEN = ups_pkg::DEFAULT_MAX_LEN
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  ups_pkg::cmd_t cmd,
    output ups_pkg::sts_t sts,
    input  logic          in_valid,
    output logic          in_stall,
    input  logic [7:0]    in_byte,
    input  logic          in_last,
    output logic          out_valid,
    input  logic          out_stall,
    output logic [7:0]    out_byte,
    output logic          out_last,
    output logic          out_empty,
    output logic          out_overflow
);

    localparam int AW = $clog2(MAX_LEN);
    localparam int CW = $clog2(MAX_LEN + 1);
    localparam int KW = $clog2(MAX_LEN + 3);

    logic [7:0]    mem [MAX_LEN];
    logic [7:0]    rd_data_reg;

    logic [CW-1:0] fill_reg;
    logic          ovf_reg;
    logic [CW-1:0] len_reg;
    logic [KW-1:0] rd_idx_reg;
    logic          tok_vld_reg;
    logic [KW-1:0] tok_pos_reg;
    logic          tok_in_reg;
    logic [7:0]    hist1_reg;
    logic [7:0]    hist0_reg;
    logic          found_reg;
    logic [KW-1:0] post_reg;
    logic          prev_slash_reg;
    logic [CW-1:0] wr_cnt_reg;
    logic [7:0]    wa_reg;
    logic [7:0]    wb_reg;
    logic          va_reg;
    logic          vb_reg;
    logic [1:0]    skip_reg;
    logic          stop_reg;
    logic          out_vld_reg;
    logic [7:0]    out_byte_reg;
    logic          out_last_reg;
    logic          out_empty_reg;
    logic          out_ovf_reg;

    logic          accept;
    logic          room;
    logic [CW-1:0] fill_after;
    logic [KW-1:0] limit;
    logic          issue;
    logic          rd_en;
    logic          wr_en;
    logic [AW-1:0] wr_addr;
    logic [7:0]    wr_data;
    logic          keep;
    logic          at_post;
    logic          proc;
    logic [4:0]    hi_nib;
    logic [4:0]    lo_nib;
    logic [7:0]    esc_code;
    logic          esc_hit;
    logic [7:0]    dec_char;
    logic          term;
    logic          scan_hit;

    assign in_stall     = (cmd.op != ups_pkg::OP_LOAD);
    assign accept       = in_valid && (cmd.op == ups_pkg::OP_LOAD);
    assign room         = (fill_reg < CW'(MAX_LEN));
    assign fill_after   = room ? (fill_reg + CW'(1)) : fill_reg;
    assign out_valid    = out_vld_reg;
    assign out_byte     = out_byte_reg;
    assign out_last     = out_last_reg;
    assign out_empty    = out_empty_reg;
    assign out_overflow = out_ovf_reg;

    // Pass length and read issue
    always_comb
    begin
        limit = '0;
        issue = 1'b0;
        case (cmd.op)
            ups_pkg::OP_SCAN,
            ups_pkg::OP_COLLAPSE:
            begin
                limit = KW'(len_reg);
                issue = (rd_idx_reg < limit);
            end
            ups_pkg::OP_DECODE:
            begin
                limit = KW'(len_reg) + KW'(2);
                issue = (rd_idx_reg < limit);
            end
            ups_pkg::OP_EMIT:
            begin
                limit = (len_reg == '0) ? KW'(1) : KW'(len_reg);
                issue = (rd_idx_reg < limit) && !tok_vld_reg
                        && (!out_vld_reg || !out_stall);
            end
            default:
            begin
                limit = '0;
                issue = 1'b0;
            end
        endcase
    end

    assign rd_en          = issue && (rd_idx_reg < KW'(len_reg));
    assign sts.last_taken = accept && in_last;
    assign sts.sweep_done = (cmd.op != ups_pkg::OP_LOAD) && (rd_idx_reg == limit)
                            && !tok_vld_reg;

    // Per-token work
    assign scan_hit = tok_vld_reg && !found_reg && (hist1_reg == ups_pkg::CH_COLON)
                      && (hist0_reg == ups_pkg::CH_SLASH)
                      && (rd_data_reg == ups_pkg::CH_SLASH);
    assign at_post  = (tok_pos_reg >= post_reg);
    assign keep     = !(at_post && (rd_data_reg == ups_pkg::CH_SLASH) && prev_slash_reg);

    assign proc     = tok_vld_reg && va_reg && !stop_reg;
    assign hi_nib   = ups_pkg::hex_nibble(wb_reg);
    assign lo_nib   = ups_pkg::hex_nibble(rd_data_reg);
    assign esc_code = {hi_nib[3:0], lo_nib[3:0]};
    assign esc_hit  = (wa_reg == ups_pkg::CH_PCT) && tok_in_reg && hi_nib[4] && lo_nib[4]
                      && ups_pkg::esc_known(esc_code);
    assign dec_char = esc_hit ? esc_code : wa_reg;
    assign term     = (dec_char == ups_pkg::CH_QMARK) || (dec_char == ups_pkg::CH_HASH);

    always_comb
    begin
        wr_en   = 1'b0;
        wr_addr = wr_cnt_reg[AW-1:0];
        wr_data = rd_data_reg;
        case (cmd.op)
            ups_pkg::OP_LOAD:
            begin
                wr_en   = accept && room;
                wr_addr = fill_reg[AW-1:0];
                wr_data = in_byte;
            end
            ups_pkg::OP_COLLAPSE:
            begin
                wr_en = tok_vld_reg && keep;
            end
            ups_pkg::OP_DECODE:
            begin
                wr_en   = proc && (skip_reg == 2'd0) && !term;
                wr_data = dec_char;
            end
            default:
            begin
                wr_en = 1'b0;
            end
        endcase
    end

    // Buffer memory, registered read
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_idx_reg[AW-1:0]];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg       <= '0;
            ovf_reg        <= 1'b0;
            len_reg        <= '0;
            rd_idx_reg     <= '0;
            tok_vld_reg    <= 1'b0;
            tok_pos_reg    <= '0;
            tok_in_reg     <= 1'b0;
            hist1_reg      <= 8'h00;
            hist0_reg      <= 8'h00;
            found_reg      <= 1'b0;
            post_reg       <= '0;
            prev_slash_reg <= 1'b0;
            wr_cnt_reg     <= '0;
            wa_reg         <= 8'h00;
            wb_reg         <= 8'h00;
            va_reg         <= 1'b0;
            vb_reg         <= 1'b0;
            skip_reg       <= 2'd0;
            stop_reg       <= 1'b0;
            out_vld_reg    <= 1'b0;
            out_byte_reg   <= 8'h00;
            out_last_reg   <= 1'b0;
            out_empty_reg  <= 1'b0;
            out_ovf_reg    <= 1'b0;
        end
        else
        begin
            // Read token pipeline
            tok_vld_reg <= issue;
            if (issue)
            begin
                rd_idx_reg  <= rd_idx_reg + KW'(1);
                tok_pos_reg <= rd_idx_reg;
                tok_in_reg  <= (rd_idx_reg < KW'(len_reg));
            end

            if (wr_en && (cmd.op != ups_pkg::OP_LOAD))
            begin
                wr_cnt_reg <= wr_cnt_reg + CW'(1);
            end

            case (cmd.op)
                ups_pkg::OP_LOAD:
                begin
                    if (accept)
                    begin
                        fill_reg <= fill_after;
                        if (!room)
                        begin
                            ovf_reg <= 1'b1;
                        end
                    end
                end
                ups_pkg::OP_SCAN:
                begin
                    if (tok_vld_reg)
                    begin
                        hist1_reg <= hist0_reg;
                        hist0_reg <= rd_data_reg;
                    end
                    if (scan_hit)
                    begin
                        found_reg <= 1'b1;
                        post_reg  <= tok_pos_reg;
                    end
                end
                ups_pkg::OP_COLLAPSE:
                begin
                    if (tok_vld_reg && at_post)
                    begin
                        prev_slash_reg <= (rd_data_reg == ups_pkg::CH_SLASH);
                    end
                end
                ups_pkg::OP_DECODE:
                begin
                    // Shift the lookahead window
                    if (tok_vld_reg)
                    begin
                        wa_reg <= wb_reg;
                        va_reg <= vb_reg;
                        wb_reg <= rd_data_reg;
                        vb_reg <= tok_in_reg;
                    end
                    if (proc)
                    begin
                        if (skip_reg != 2'd0)
                        begin
                            skip_reg <= skip_reg - 2'd1;
                        end
                        else if (term)
                        begin
                            stop_reg <= 1'b1;
                        end
                        else if (esc_hit)
                        begin
                            skip_reg <= 2'd2;
                        end
                    end
                end
                default:
                begin
                end
            endcase

            // Output word register
            if (cmd.op == ups_pkg::OP_EMIT && tok_vld_reg)
            begin
                out_vld_reg   <= 1'b1;
                out_byte_reg  <= (len_reg == '0) ? 8'h00 : rd_data_reg;
                out_last_reg  <= (tok_pos_reg == limit - KW'(1));
                out_empty_reg <= (len_reg == '0);
                out_ovf_reg   <= ovf_reg;
            end
            else if (out_vld_reg && !out_stall)
            begin
                out_vld_reg <= 1'b0;
            end

            // Pass boundaries: rewind and set up the next pass
            if (cmd.restart)
            begin
                rd_idx_reg <= '0;
                case (cmd.op)
                    ups_pkg::OP_LOAD:
                    begin
                        len_reg   <= fill_after;
                        hist1_reg <= 8'h00;
                        hist0_reg <= 8'h00;
                        found_reg <= 1'b0;
                        post_reg  <= '0;
                    end
                    ups_pkg::OP_SCAN:
                    begin
                        prev_slash_reg <= 1'b0;
                        wr_cnt_reg     <= '0;
                    end
                    ups_pkg::OP_COLLAPSE:
                    begin
                        len_reg    <= wr_cnt_reg;
                        wr_cnt_reg <= '0;
                        va_reg     <= 1'b0;
                        vb_reg     <= 1'b0;
                        skip_reg   <= 2'd0;
                        stop_reg   <= 1'b0;
                    end
                    ups_pkg::OP_DECODE:
                    begin
                        len_reg <= wr_cnt_reg;
                    end
                    ups_pkg::OP_EMIT:
                    begin
                        fill_reg <= '0;
                        ovf_reg  <= 1'b0;
                    end
                    default:
                    begin
                    end
                endcase
            end
        end
    end

endmodule

>>> hw/rtl/url_path_sanitiser.sv
// ----------------------------------------------------------------------------
// url_path_sanitiser: slash collapse, escape decode and query cut for a URL
// Throughput: words load one per cycle during the load pass and are stalled
//   in every other pass; an emit read starts only once the previous word sits
//   in the output register.
// Reset: asynchronous, active low; clears the sequencer, counts and flags.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "url_path_sanitiser_defines.svh"

module url_path_sanitiser
#(
    parameter int MAX_LEN = ups_pkg::DEFAULT_MAX_LEN
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] in_byte,
    input  logic       in_last,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [7:0] out_byte,
    output logic       out_last,
    output logic       out_empty,
    output logic       out_overflow
);

    // How a URL moves through the block:
    //   load     - take words into the buffer, one per cycle; drop words past
    //              MAX_LEN and remember the overflow.
    //   scan     - sweep the buffer for the first "://" and latch the position
    //              of its second slash (zero when absent).
    //   collapse - sweep again and compact the buffer in place, dropping every
    //              slash that follows a slash from that position onward.
    //   decode   - sweep with a two-word lookahead window, replace the known
    //              percent escapes and stop at the first '?' or '#'.
    //   emit     - read the result out through the output register; an empty
    //              result still gives one word flagged empty.
    // Input words are stalled from the final word of a URL until emit ends.
    // The output register parts the two sides, so the next URL may load while
    // the last result word waits.

    ups_pkg::cmd_t cmd;
    ups_pkg::sts_t sts;

    ups_ctrl u_ctrl
    (
        .clk   (clk),
        .rst_n (rst_n),
        .sts   (sts),
        .cmd   (cmd)
    );

    ups_dp
    #(
        .MAX_LEN (MAX_LEN)
    )
    u_dp
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .sts          (sts),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .in_byte      (in_byte),
        .in_last      (in_last),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .out_byte     (out_byte),
        .out_last     (out_last),
        .out_empty    (out_empty),
        .out_overflow (out_overflow)
    );

    // An empty result is a single closing word with a zero byte.
    `UPS_ASSERT_IMP(a_empty_closes, clk, rst_n, out_valid && out_empty, out_last && (out_byte == 8'h00))

    // A result word only ever comes out of the emit pass.
    `UPS_ASSERT_IMP(a_word_from_emit, clk, rst_n, $rose(out_valid), $past(cmd.op) == ups_pkg::OP_EMIT)

    // After the final word of a URL, hold off further input.
    `UPS_ASSERT_NXT(a_hold_after_last, clk, rst_n, sts.last_taken, in_stall)

endmodule
